/* rtl/dqts_pkg.sv */
package dqts_pkg;

	localparam int MaxTasks = 16;
	localparam int IdxW = $clog2(MaxTasks);
	localparam int CntW = 7;

	localparam logic [2:0] MODE_TICK = 3'd0;
	localparam logic [2:0] MODE_ADD = 3'd1;
	localparam logic [2:0] MODE_DEL = 3'd2;
	localparam logic [2:0] MODE_DISP = 3'd3;
	localparam logic [2:0] MODE_CLR = 3'd4;

	localparam logic [1:0] ST_NORMAL = 2'd0;
	localparam logic [1:0] ST_TOO_MANY = 2'd1;
	localparam logic [1:0] ST_NO_DELETE = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_EXEC, S_SCAN, S_SHIFT_UP, S_SHIFT_DN, S_HEAD, S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic exec;
		logic scan_step;
		logic up_step;
		logic dn_step;
		logic ins_write;
		logic start_scan;
		logic start_dn;
	} dp_cmd_t;

	typedef struct packed {
		logic add_go;
		logic del_go;
		logic disp_go;
		logic scan_done;
		logic up_done;
		logic dn_done;
		logic readd_go;
	} dp_sts_t;

endpackage

/* rtl/dqts_ctrl.sv */
module dqts_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input dqts_pkg::dp_sts_t sts,
	output dqts_pkg::dp_cmd_t cmd
);
	import dqts_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_RD;
				end
			end
			S_RD: begin
				cmd.rd = 1'b1;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (sts.add_go) begin
					cmd.start_scan = 1'b1;
					state_d = S_SCAN;
				end else if (sts.del_go || sts.disp_go) begin
					cmd.start_dn = 1'b1;
					state_d = S_SHIFT_DN;
				end else state_d = S_DONE;
			end
			S_SCAN: begin
				// last step captures the insert slot
				cmd.scan_step = 1'b1;
				if (sts.scan_done) state_d = S_SHIFT_UP;
			end
			S_SHIFT_UP: begin
				if (sts.up_done) begin
					cmd.ins_write = 1'b1;
					state_d = S_DONE;
				end else cmd.up_step = 1'b1;
			end
			S_SHIFT_DN: begin
				if (sts.dn_done) state_d = S_HEAD;
				else cmd.dn_step = 1'b1;
			end
			S_HEAD: begin
				if (sts.readd_go) begin
					cmd.start_scan = 1'b1;
					state_d = S_SCAN;
				end else state_d = S_DONE;
			end
			S_DONE: begin
				out_valid = 1'b1;
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

/* rtl/dqts_dp.sv */
module dqts_dp (
	input logic clk,
	input logic arst_n,
	input dqts_pkg::dp_cmd_t cmd,
	output dqts_pkg::dp_sts_t sts,
	input logic [2:0] mode,
	input logic [7:0] task_handle,
	input logic [31:0] first_delay,
	input logic [31:0] repeat_period,
	input logic [7:0] task_position,
	output logic [6:0] assigned_id,
	output logic [1:0] op_status,
	output logic ran_task,
	output logic [7:0] ran_handle,
	output logic [1:0] last_error
);
	import dqts_pkg::*;

	typedef struct packed {
		logic [31:0] dly;
		logic [31:0] per;
		logic [7:0] runs;
		logic [7:0] hdl;
		logic [5:0] id;
	} slot_t;

	slot_t slots_q [MaxTasks];
	logic [CntW-1:0] count_q;
	logic [1:0] err_q;

	logic [2:0] mode_q;
	logic [7:0] hdl_q, pos_q;
	logic [31:0] dly_q, per_q;
	logic [32:0] cum_q;
	logic [CntW-1:0] ptr_q;
	logic [CntW-1:0] ins_q;
	logic [31:0] rel_q;
	logic [6:0] id_q;
	logic [1:0] st_q;
	logic ran_q;
	logic [7:0] ranh_q;
	slot_t head_q;

	slot_t scan_e, up_e, dn_e;
	logic [32:0] cum_nx;
	logic scan_hit;
	logic full;

	assign full = count_q >= CntW'(MaxTasks);
	assign scan_e = slots_q[ptr_q[IdxW-1:0]];
	assign up_e = slots_q[IdxW'(ptr_q - 1'b1)];
	assign dn_e = slots_q[IdxW'(ptr_q + 1'b1)];
	assign cum_nx = cum_q + {1'b0, scan_e.dly};
	assign scan_hit = cum_nx > {1'b0, dly_q};

	assign sts.add_go = (mode_q == MODE_ADD) && !full;
	assign sts.del_go = (mode_q == MODE_DEL) && ({1'b0, pos_q} < {2'b00, count_q});
	assign sts.disp_go = (mode_q == MODE_DISP) && (count_q != '0) && (head_q.runs != 8'd0);
	assign sts.scan_done = (ptr_q >= count_q) || scan_hit;
	assign sts.up_done = ptr_q <= ins_q;
	// count is already reduced while shifting down
	assign sts.dn_done = ptr_q >= count_q;
	assign sts.readd_go = ran_q && (per_q != 32'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			err_q <= ST_NORMAL;
		end else begin
			if (cmd.exec) begin
				case (mode_q)
					MODE_TICK: ;
					MODE_ADD: if (full) err_q <= ST_TOO_MANY;
					MODE_DEL: if (!sts.del_go) err_q <= ST_NO_DELETE;
					MODE_CLR: begin
						count_q <= '0;
						err_q <= ST_NORMAL;
					end
					default: ;
				endcase
			end
			if (cmd.start_dn) count_q <= count_q - 1'b1;
			if (cmd.ins_write) count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			hdl_q <= task_handle;
			dly_q <= first_delay;
			per_q <= repeat_period;
			pos_q <= task_position;
		end
		if (cmd.rd) begin
			head_q <= slots_q[0];
			id_q <= '0;
			st_q <= ST_NORMAL;
			ran_q <= 1'b0;
			ranh_q <= '0;
		end
		if (cmd.exec) begin
			case (mode_q)
				MODE_TICK: if (count_q != '0) begin
					if (head_q.dly != 32'd0) slots_q[0].dly <= head_q.dly - 1'b1;
					else if (head_q.runs != 8'hff) slots_q[0].runs <= head_q.runs + 1'b1;
				end
				MODE_ADD: begin
					if (full) begin
						id_q <= 7'(MaxTasks);
						st_q <= ST_TOO_MANY;
					end else id_q <= count_q;
				end
				MODE_DEL: if (!sts.del_go) st_q <= ST_NO_DELETE;
				MODE_DISP: if (sts.disp_go) begin
					ran_q <= 1'b1;
					ranh_q <= head_q.hdl;
					hdl_q <= head_q.hdl;
					dly_q <= head_q.per;
					per_q <= head_q.per;
				end
				default: ;
			endcase
		end
		// delete and dispatch start shifting at the removed slot
		if (cmd.start_scan) ptr_q <= '0;
		else if (cmd.exec) ptr_q <= (mode_q == MODE_DEL) ? CntW'(pos_q) : '0;
		else if (cmd.scan_step) begin
			if (scan_hit || ptr_q >= count_q) ptr_q <= count_q;
			else ptr_q <= ptr_q + 1'b1;
		end else if (cmd.up_step) ptr_q <= ptr_q - 1'b1;
		else if (cmd.dn_step) ptr_q <= ptr_q + 1'b1;
		if (cmd.start_scan) cum_q <= '0;
		if (cmd.scan_step) begin
			if (scan_hit || ptr_q >= count_q) begin
				ins_q <= ptr_q;
				rel_q <= 32'(({1'b0, dly_q} - cum_q));
			end else cum_q <= cum_nx;
		end
		if (cmd.up_step) slots_q[IdxW'(ptr_q)] <= up_e;
		if (cmd.dn_step) begin
			slots_q[IdxW'(ptr_q)] <=
				(ptr_q == ((mode_q == MODE_DEL) ? CntW'(pos_q) : CntW'(0)))
				? '{dly: dn_e.dly + scan_e.dly, per: dn_e.per, runs: dn_e.runs,
					hdl: dn_e.hdl, id: dn_e.id}
				: dn_e;
		end
		if (cmd.ins_write) begin
			if (ins_q < count_q)
				slots_q[IdxW'(ins_q) + IdxW'(1)].dly <= slots_q[IdxW'(ins_q) + IdxW'(1)].dly - rel_q;
			slots_q[IdxW'(ins_q)] <= '{dly: rel_q, per: per_q, runs: 8'd0, hdl: hdl_q,
				id: 6'(count_q)};
		end
	end

	assign assigned_id = id_q;
	assign op_status = st_q;
	assign ran_task = ran_q;
	assign ran_handle = ranh_q;
	assign last_error = err_q;

endmodule

/* rtl/delta_queue_task_scheduler_core.sv */
// failed commands, tick and clear only execute; add scans then shifts up; delete
// and dispatch shift down, and a dispatch with re-add then scans and shifts up
// one command at a time; the sorted scan and slot shifts move one slot per cycle
// reset: arst_n clears the task count, the sticky error and the controller state
// slot contents are not cleared and are only read below the task count
module delta_queue_task_scheduler_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [2:0] mode,
	input logic [7:0] task_handle,
	input logic [31:0] first_delay,
	input logic [31:0] repeat_period,
	input logic [7:0] task_position,
	output logic out_valid,
	input logic out_ready,
	output logic [6:0] assigned_id,
	output logic [1:0] op_status,
	output logic ran_task,
	output logic [7:0] ran_handle,
	output logic [1:0] last_error
);
	import dqts_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	dqts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);

	dqts_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .mode(mode),
		.task_handle(task_handle), .first_delay(first_delay),
		.repeat_period(repeat_period), .task_position(task_position),
		.assigned_id(assigned_id), .op_status(op_status), .ran_task(ran_task),
		.ran_handle(ran_handle), .last_error(last_error)
	);

`ifndef NO_ASSERTIONS
	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	a_ran_handle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ran_task |-> ran_handle == 8'd0) else $error("stray handle");
	a_fail_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && op_status == ST_TOO_MANY |-> assigned_id == 7'(MaxTasks))
		else $error("bad failed id");
`endif

endmodule

/* test/tb_delta_queue_task_scheduler_core.sv */
`timescale 1ns / 1ps
module tb_delta_queue_task_scheduler_core;
	import dqts_pkg::*;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] handle;
		logic [31:0] delay;
		logic [31:0] period;
		logic [7:0] position;
	} cmd_t;

	typedef struct packed {
		logic [6:0] id;
		logic [1:0] status;
		logic ran;
		logic [7:0] ran_h;
		logic [1:0] err;
	} res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] mode = '0;
	logic [7:0] task_handle = '0;
	logic [31:0] first_delay = '0;
	logic [31:0] repeat_period = '0;
	logic [7:0] task_position = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [6:0] assigned_id;
	logic [1:0] op_status;
	logic ran_task;
	logic [7:0] ran_handle;
	logic [1:0] last_error;

	delta_queue_task_scheduler_core i_dut (.*);

	always #5 clk = ~clk;

	cmd_t pending_cmds[$];
	res_t expected_results[$];
	int errors = 0;
	int send_idle = 20;
	int recv_idle = 54;
	int phase = 0;
	bit holding = 1'b0;

	// scheduler shadow state
	logic [31:0] sh_delay[MaxTasks];
	logic [31:0] sh_period[MaxTasks];
	logic [7:0] sh_runs[MaxTasks];
	logic [7:0] sh_handle[MaxTasks];
	logic [5:0] sh_id[MaxTasks];
	int sh_count = 0;
	logic [1:0] sh_err = ST_NORMAL;

	function automatic bit sched_insert(logic [7:0] h, logic [31:0] d, logic [31:0] p);
		int pos;
		logic [32:0] cum;
		logic [32:0] prev;
		logic [31:0] rel;
		pos = sh_count;
		cum = '0;
		if (sh_count >= MaxTasks) return 0;
		for (int i = 0; i < sh_count; i++) begin
			prev = cum;
			cum = cum + {1'b0, sh_delay[i]};
			if (cum > {1'b0, d}) begin
				pos = i;
				cum = prev;
				break;
			end
		end
		rel = 32'(({1'b0, d}) - cum);
		if (pos < sh_count) begin
			sh_delay[pos] = sh_delay[pos] - rel;
			for (int i = sh_count; i > pos; i--) begin
				sh_delay[i] = sh_delay[i-1];
				sh_period[i] = sh_period[i-1];
				sh_runs[i] = sh_runs[i-1];
				sh_handle[i] = sh_handle[i-1];
				sh_id[i] = sh_id[i-1];
			end
		end
		sh_delay[pos] = rel;
		sh_period[pos] = p;
		sh_runs[pos] = '0;
		sh_handle[pos] = h;
		sh_id[pos] = 6'(sh_count);
		sh_count++;
		return 1;
	endfunction

	function automatic void sched_remove(int pos);
		if (pos + 1 < sh_count) sh_delay[pos+1] = sh_delay[pos+1] + sh_delay[pos];
		for (int i = pos; i + 1 < sh_count; i++) begin
			sh_delay[i] = sh_delay[i+1];
			sh_period[i] = sh_period[i+1];
			sh_runs[i] = sh_runs[i+1];
			sh_handle[i] = sh_handle[i+1];
			sh_id[i] = sh_id[i+1];
		end
		sh_count--;
	endfunction

	function automatic res_t sched_step(cmd_t c);
		res_t r;
		logic [31:0] p;
		r = '0;
		case (c.mode)
			MODE_TICK: if (sh_count > 0) begin
				if (sh_delay[0] > 0) sh_delay[0]--;
				else if (sh_runs[0] < 8'd255) sh_runs[0]++;
			end
			MODE_ADD: begin
				r.id = 7'(sh_count);
				if (!sched_insert(c.handle, c.delay, c.period)) begin
					sh_err = ST_TOO_MANY;
					r.status = ST_TOO_MANY;
					r.id = 7'(MaxTasks);
				end
			end
			MODE_DEL: begin
				if (int'(c.position) >= sh_count) begin
					sh_err = ST_NO_DELETE;
					r.status = ST_NO_DELETE;
				end else sched_remove(int'(c.position));
			end
			MODE_DISP: if (sh_count > 0 && sh_runs[0] > 0) begin
				p = sh_period[0];
				r.ran = 1'b1;
				r.ran_h = sh_handle[0];
				sched_remove(0);
				if (p > 0) void'(sched_insert(r.ran_h, p, p));
			end
			MODE_CLR: begin
				sh_count = 0;
				sh_err = ST_NORMAL;
			end
			default: ;
		endcase
		r.err = sh_err;
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("error: %s got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_ready) begin
				if (in_valid) expected_results.push_back(sched_step({mode, task_handle,
					first_delay, repeat_period, task_position}));
				if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle) begin
					cmd_t c;
					c = pending_cmds.pop_front();
					in_valid <= 1'b1;
					mode <= c.mode;
					task_handle <= c.handle;
					first_delay <= c.delay;
					repeat_period <= c.period;
					task_position <= c.position;
				end else in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				res_t w;
				if (expected_results.size() == 0) report("unexpected item", 0, 0);
				else begin
					w = expected_results.pop_front();
					if (assigned_id !== w.id)
						report("assigned_id", 32'(assigned_id), 32'(w.id));
					if (op_status !== w.status)
						report("op_status", 32'(op_status), 32'(w.status));
					if (ran_task !== w.ran) report("ran_task", 32'(ran_task), 32'(w.ran));
					if (ran_handle !== w.ran_h)
						report("ran_handle", 32'(ran_handle), 32'(w.ran_h));
					if (last_error !== w.err)
						report("last_error", 32'(last_error), 32'(w.err));
				end
			end
			if (holding) out_ready <= 1'b0;
			else out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// long receiver stall in the second random phase
	initial begin
		wait (phase == 1);
		holding = 1'b1;
		repeat (300) @(posedge clk);
		holding = 1'b0;
	end

	function automatic cmd_t mk(logic [2:0] m, logic [7:0] h, logic [31:0] d,
		logic [31:0] p, logic [7:0] pos);
		cmd_t c;
		c.mode = m; c.handle = h; c.delay = d; c.period = p; c.position = pos;
		return c;
	endfunction

	function automatic logic [31:0] rnd_delay();
		case ($urandom_range(9))
			0: return $urandom();
			1: return 32'hFFFF_FFFF - $urandom_range(3);
			2: return 0;
			default: return $urandom_range(12);
		endcase
	endfunction

	function automatic cmd_t rnd_cmd();
		int r;
		r = int'($urandom_range(99));
		if (r < 40) return mk(MODE_TICK, 8'($urandom()), $urandom(), $urandom(),
			8'($urandom()));
		if (r < 62) return mk(MODE_ADD, 8'($urandom()), rnd_delay(),
			($urandom_range(2) == 0) ? 32'd0 : rnd_delay(), 8'($urandom()));
		if (r < 72) return mk(MODE_DEL, 8'($urandom()), $urandom(), $urandom(),
			($urandom_range(4) == 0) ? 8'($urandom()) : 8'($urandom_range(17)));
		if (r < 95) return mk(MODE_DISP, 8'($urandom()), $urandom(), $urandom(),
			8'($urandom()));
		if (r < 97) return mk(MODE_CLR, 8'($urandom()), $urandom(), $urandom(),
			8'($urandom()));
		return mk(3'($urandom_range(7, 5)), 8'($urandom()), $urandom(), $urandom(),
			8'($urandom()));
	endfunction

	task automatic drain();
		while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		// directed: empty list cases, extremes, full list, equal due times
		pending_cmds.push_back(mk(MODE_TICK, 0, 0, 0, 0));
		pending_cmds.push_back(mk(MODE_DISP, 0, 0, 0, 0));
		pending_cmds.push_back(mk(MODE_DEL, 0, 0, 0, 8'hFF));
		pending_cmds.push_back(mk(MODE_ADD, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
		pending_cmds.push_back(mk(MODE_ADD, 8'h00, 0, 0, 0));
		pending_cmds.push_back(mk(MODE_ADD, 8'h5A, 0, 1, 0));
		pending_cmds.push_back(mk(MODE_TICK, 0, 0, 0, 0));
		pending_cmds.push_back(mk(MODE_DISP, 0, 0, 0, 0));
		pending_cmds.push_back(mk(MODE_DISP, 0, 0, 0, 0));
		pending_cmds.push_back(mk(MODE_DEL, 0, 0, 0, 0));
		pending_cmds.push_back(mk(3'd7, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
		for (int i = 0; i < 16; i++)
			pending_cmds.push_back(mk(MODE_ADD, 8'(i), 32'(i % 3), 32'(i & 1), 0));
		pending_cmds.push_back(mk(MODE_CLR, 0, 0, 0, 0));
		drain();
		// random with a long receiver stall to fill the block
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 20 : (ph == 1) ? 54 : 0;
			recv_idle = (ph == 0) ? 54 : (ph == 1) ? 20 : 0;
			phase = ph;
			for (int i = 0; i < 250; i++) pending_cmds.push_back(rnd_cmd());
			drain();
		end
		repeat (100) @(posedge clk);
		if (errors == 0) $display("delta_queue_task_scheduler_core: match");
		else $display("delta_queue_task_scheduler_core: mismatch");
		$finish;
	end

	initial begin
		#20ms;
		$display("delta_queue_task_scheduler_core: mismatch");
		$finish;
	end
endmodule

/* delta_queue_task_scheduler_core.f */
rtl/dqts_pkg.sv
rtl/dqts_ctrl.sv
rtl/dqts_dp.sv
rtl/delta_queue_task_scheduler_core.sv
test/tb_delta_queue_task_scheduler_core.sv
